// ----- design/annexb_nal_unit_splitter_macros.svh -----
// assertion macros for the annex b nal unit splitter checker
// no dependencies; taken in by the checker file
`ifndef ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH

// checked only outside reset
`define ANXB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define ANXB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/anxb_pkg.sv -----
// shared types and constants of the annex b nal unit splitter
// no dependencies; used by every module of the block
package anxb_pkg;

  localparam int unsigned TicksW   = 17;
  localparam int unsigned StampW   = 32;
  localparam int unsigned QueueAw  = 2;
  localparam int unsigned QueueDepth = 1 << QueueAw;

  localparam logic [TicksW-1:0] TicksReset = TicksW'(3000);
  localparam logic [4:0]        SpsType    = 5'd7;
  localparam logic [7:0]        ByteZero   = 8'h00;
  localparam logic [7:0]        ByteOne    = 8'h01;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic              unit_last;
    logic              frame_marker;
    logic [StampW-1:0] stamp;
    logic              bad_frame;
  } out_item_t;

  // one parsed input byte: [p_byte] [zeros x 0] [t_byte], flags on the final one
  typedef struct packed {
    logic              bad;
    logic              p_vld;
    logic [7:0]        p_byte;
    logic [1:0]        zeros;
    logic              t_vld;
    logic [7:0]        t_byte;
    logic              fin_last;
    logic              fin_mark;
    logic [StampW-1:0] stamp;
  } rec_t;

endpackage

// ----- design/anxb_front.sv -----
// front end: start code parser, nal type check, frame stamp and tick register
// depends on anxb_pkg; writes a burst record for each accepted byte that yields results
module anxb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  anxb_pkg::in_item_t           in_item_i,
  input  logic                         cfg_we_i,
  input  logic [anxb_pkg::TicksW-1:0]  cfg_data_i,
  output logic                         rec_valid_o,
  output anxb_pkg::rec_t               rec_o
);

  typedef enum logic [1:0] {PhExpect, PhDrop, PhHeader, PhBody} phase_e;

  phase_e                       phase_q, phase_d;
  logic [1:0]                   hc_q, hc_d;
  logic                         lco_q, lco_d;
  logic                         pend_vld_q, pend_vld_d;
  logic [7:0]                   pend_byte_q, pend_byte_d;
  logic [anxb_pkg::StampW-1:0]  stamp_q, stamp_d;
  logic [anxb_pkg::TicksW-1:0]  ticks_q, ticks_d;
  logic                         bad;
  logic                         body_en;
  logic [1:0]                   full_cnt;
  logic [7:0]                   b;
  logic                         fend;
  anxb_pkg::rec_t               rec;

  assign b    = in_item_i.stream_byte;
  assign fend = in_item_i.frame_end;

  always_comb begin
    phase_d     = phase_q;
    hc_d        = hc_q;
    lco_d       = lco_q;
    pend_vld_d  = pend_vld_q;
    pend_byte_d = pend_byte_q;
    stamp_d     = stamp_q;
    ticks_d     = cfg_we_i ? cfg_data_i : ticks_q;
    bad         = 1'b0;
    body_en     = 1'b0;
    rec         = '0;
    rec.stamp   = stamp_q;

    unique case (phase_q)
      PhExpect: begin
        if (b == anxb_pkg::ByteZero && hc_q != 2'd3) begin
          hc_d = hc_q + 2'd1;
        end else if (b == anxb_pkg::ByteOne && hc_q[1]) begin
          hc_d    = 2'd0;
          phase_d = PhHeader;
        end else begin
          bad = 1'b1;
        end
        // frame ended before its opening code was complete
        if (!bad && fend && phase_d == PhExpect) begin
          bad = 1'b1;
        end
        if (bad) begin
          hc_d    = 2'd0;
          phase_d = PhDrop;
        end
      end
      PhHeader: begin
        lco_d   = (b[4:0] == anxb_pkg::SpsType);
        phase_d = PhBody;
        body_en = 1'b1;
      end
      PhBody: begin
        body_en = 1'b1;
      end
      PhDrop: begin
      end
      default: begin
      end
    endcase

    // sps units end only on the four byte code
    full_cnt = lco_d ? 2'd3 : 2'd2;

    if (body_en) begin
      if (b == anxb_pkg::ByteZero) begin
        if (hc_q != full_cnt) begin
          hc_d = hc_q + 2'd1;
        end else begin
          rec.p_vld   = pend_vld_q;
          rec.p_byte  = pend_byte_q;
          pend_byte_d = anxb_pkg::ByteZero;
          pend_vld_d  = 1'b1;
        end
      end else if (b == anxb_pkg::ByteOne && hc_q == full_cnt) begin
        rec.p_vld    = pend_vld_q;
        rec.p_byte   = pend_byte_q;
        rec.fin_last = pend_vld_q;
        pend_vld_d   = 1'b0;
        hc_d         = 2'd0;
        phase_d      = PhHeader;
      end else begin
        rec.p_vld   = pend_vld_q;
        rec.p_byte  = pend_byte_q;
        rec.zeros   = hc_q;
        hc_d        = 2'd0;
        pend_byte_d = b;
        pend_vld_d  = 1'b1;
      end
    end

    if (fend) begin
      if (phase_d == PhBody) begin
        // flush pending byte and held zeros, keeping stream order
        if (!rec.p_vld && rec.zeros == 2'd0) begin
          rec.p_vld  = pend_vld_d;
          rec.p_byte = pend_byte_d;
          rec.zeros  = hc_d;
        end else begin
          rec.t_vld  = pend_vld_d;
          rec.t_byte = pend_byte_d;
          rec.zeros  = rec.zeros | hc_d;
        end
        rec.fin_last = 1'b1;
        rec.fin_mark = 1'b1;
      end
      phase_d    = PhExpect;
      hc_d       = 2'd0;
      pend_vld_d = 1'b0;
      lco_d      = 1'b0;
      stamp_d    = stamp_q + anxb_pkg::StampW'(ticks_q);
    end

    rec.bad = bad;
  end

  assign rec_o       = rec;
  assign rec_valid_o = in_valid_i &&
                       (rec.bad || rec.p_vld || rec.t_vld || rec.zeros != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhExpect;
      hc_q        <= 2'd0;
      lco_q       <= 1'b0;
      pend_vld_q  <= 1'b0;
      pend_byte_q <= anxb_pkg::ByteZero;
      stamp_q     <= '0;
      ticks_q     <= anxb_pkg::TicksReset;
    end else begin
      if (in_valid_i) begin
        phase_q     <= phase_d;
        hc_q        <= hc_d;
        lco_q       <= lco_d;
        pend_vld_q  <= pend_vld_d;
        pend_byte_q <= pend_byte_d;
        stamp_q     <= stamp_d;
      end
      ticks_q <= ticks_d;
    end
  end

endmodule

// ----- design/anxb_queue.sv -----
// short record queue between parser and serializer
// depends on anxb_pkg for the record type and depth
module anxb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  anxb_pkg::rec_t data_i,
  input  logic           pop_i,
  output anxb_pkg::rec_t data_o,
  output logic           full_o,
  output logic           empty_o
);

  anxb_pkg::rec_t                 mem_q [anxb_pkg::QueueDepth];
  logic [anxb_pkg::QueueAw:0]     wr_ptr_q, wr_ptr_d;
  logic [anxb_pkg::QueueAw:0]     rd_ptr_q, rd_ptr_d;
  logic                           do_push;
  logic                           do_pop;

  assign full_o  = (wr_ptr_q[anxb_pkg::QueueAw] != rd_ptr_q[anxb_pkg::QueueAw]) &&
                   (wr_ptr_q[anxb_pkg::QueueAw-1:0] == rd_ptr_q[anxb_pkg::QueueAw-1:0]);
  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q[anxb_pkg::QueueAw-1:0]];

  assign wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q[anxb_pkg::QueueAw-1:0]] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

endmodule

// ----- design/anxb_back.sv -----
// back end: expands burst records into single result bytes, output register
// depends on anxb_pkg; reads records from anxb_queue
module anxb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  anxb_pkg::rec_t      rec_i,
  input  logic                rec_empty_i,
  output logic                rec_pop_o,
  input  logic                pop_i,
  output logic                out_empty_o,
  output anxb_pkg::out_item_t out_item_o
);

  anxb_pkg::rec_t      cur_q, cur_d;
  logic                cur_vld_q, cur_vld_d;
  logic                rem_p_q, rem_p_d;
  logic [1:0]          rem_z_q, rem_z_d;
  logic                rem_t_q, rem_t_d;
  logic                out_vld_q, out_vld_d;
  anxb_pkg::out_item_t out_q, out_d;
  anxb_pkg::out_item_t item;
  logic [2:0]          cnt;
  logic                final_item;
  logic                can_load;
  logic                step;
  logic                take;

  assign cnt = cur_q.bad ? 3'd1
                         : ({2'b0, rem_p_q} + {2'b0, rem_t_q} + {1'b0, rem_z_q});
  assign final_item = (cnt == 3'd1);
  assign can_load   = !out_vld_q || pop_i;
  assign step       = cur_vld_q && can_load;
  // next record loads as the current one gives its final byte
  assign take       = (!cur_vld_q || (step && final_item)) && !rec_empty_i;
  assign rec_pop_o  = take;

  always_comb begin
    item.stamp     = cur_q.stamp;
    item.bad_frame = cur_q.bad;
    if (cur_q.bad) begin
      item.payload_byte = anxb_pkg::ByteZero;
    end else if (rem_p_q) begin
      item.payload_byte = cur_q.p_byte;
    end else if (rem_z_q != 2'd0) begin
      item.payload_byte = anxb_pkg::ByteZero;
    end else begin
      item.payload_byte = cur_q.t_byte;
    end
    item.unit_last    = !cur_q.bad && final_item && cur_q.fin_last;
    item.frame_marker = !cur_q.bad && final_item && cur_q.fin_mark;
  end

  always_comb begin
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    rem_p_d   = rem_p_q;
    rem_z_d   = rem_z_q;
    rem_t_d   = rem_t_q;
    if (take) begin
      cur_d     = rec_i;
      cur_vld_d = 1'b1;
      rem_p_d   = rec_i.p_vld;
      rem_z_d   = rec_i.zeros;
      rem_t_d   = rec_i.t_vld;
    end else if (step) begin
      if (final_item) begin
        cur_vld_d = 1'b0;
      end
      if (rem_p_q) begin
        rem_p_d = 1'b0;
      end else if (rem_z_q != 2'd0) begin
        rem_z_d = rem_z_q - 2'd1;
      end else begin
        rem_t_d = 1'b0;
      end
    end

    if (step) begin
      out_vld_d = 1'b1;
      out_d     = item;
    end else begin
      out_vld_d = out_vld_q && !pop_i;
      out_d     = out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      rem_p_q   <= 1'b0;
      rem_z_q   <= 2'd0;
      rem_t_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      rem_p_q   <= rem_p_d;
      rem_z_q   <= rem_z_d;
      rem_t_q   <= rem_t_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_empty_o = !out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ----- design/annexb_nal_unit_splitter.sv -----
// Annex B NAL unit splitter, top level.
// Input queue side: push with in_data_i (stream_byte, frame_end); a byte is taken
// when push is high and full is low. One byte per cycle is sustained while full stays low.
// Result queue side: while empty is low, out_data_o holds the oldest result
// (payload_byte, unit_last, frame_marker, stamp, bad_frame); pop takes it.
// Config: cfg_valid_i/cfg_data_i write frame_ticks; cfg_ready_o is always high.
// Each byte is parsed combinationally and becomes a burst of zero to five results
// that goes through a four-entry record queue. The serializer gives one result
// per cycle while pop keeps up; results pass the queue, a record and an output register.
// Start code bytes are held back until they are resolved, so payload bytes come
// out later; the bytes held at frame end come out as a burst of up to five.
// When pop stays low the output register holds, the record queue fills, and
// full rises until results drain again.
// Reset clears all queues, sets the frame stamp to zero and frame_ticks to 3000,
// and waits for an opening start code. Depends on anxb_pkg, anxb_front, anxb_queue and anxb_back.
module annexb_nal_unit_splitter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  anxb_pkg::in_item_t          in_data_i,
  output logic                        empty,
  input  logic                        pop,
  output anxb_pkg::out_item_t         out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [anxb_pkg::TicksW-1:0] cfg_data_i
);

  logic           accept;
  logic           rec_valid;
  anxb_pkg::rec_t rec_in;
  anxb_pkg::rec_t rec_out;
  logic           rec_full;
  logic           rec_empty;
  logic           rec_pop;

  assign full        = rec_full;
  assign accept      = push && !rec_full;
  assign cfg_ready_o = 1'b1;

  anxb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_item_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .rec_valid_o (rec_valid),
    .rec_o       (rec_in)
  );

  anxb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .data_i  (rec_in),
    .pop_i   (rec_pop),
    .data_o  (rec_out),
    .full_o  (rec_full),
    .empty_o (rec_empty)
  );

  anxb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_out),
    .rec_empty_i (rec_empty),
    .rec_pop_o   (rec_pop),
    .pop_i       (pop),
    .out_empty_o (empty),
    .out_item_o  (out_data_o)
  );

endmodule

// ----- design/anxb_chk.sv -----
// port level checker for the annex b nal unit splitter, bound to the top level
// depends on anxb_pkg and annexb_nal_unit_splitter_macros.svh
`include "annexb_nal_unit_splitter_macros.svh"

module anxb_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input anxb_pkg::out_item_t out_data_o
);

  // a bad frame result carries no byte and no unit flags
  `ANXB_ASSERT(a_bad_clean, !empty && out_data_o.bad_frame |-> out_data_o.payload_byte == 8'h00 && !out_data_o.unit_last && !out_data_o.frame_marker, "bad frame result with payload")

  // the frame marker only sits on a unit's final byte
  `ANXB_ASSERT(a_mark_last, !empty && out_data_o.frame_marker |-> out_data_o.unit_last, "frame marker without unit last")

  // a waiting result stays put until taken
  `ANXB_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(out_data_o), "result changed while stalled")

  // nothing is offered while in reset
  `ANXB_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> empty, "result offered during reset")

endmodule

bind annexb_nal_unit_splitter anxb_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);
